>>> src/actr_pkg.sv
package actr_pkg;

    typedef struct packed {
        logic [63:0] block_index;
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } t_in_item;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } t_out_item;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_IV_HIGH  = 2'd2;
    localparam logic [1:0] REG_IV_LOW   = 2'd3;

    localparam logic [63:0] KEY_HIGH_RST = 64'h2E7B71D7C9C9A14E;
    localparam logic [63:0] KEY_LOW_RST  = 64'hA3221F188828B8F8;

    localparam int NUM_ROUNDS = 10;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [NUM_ROUNDS] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // Byte i of a 128-bit block sits at bits [127-8i -: 8].
    function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
        get_byte = v[127 - 8 * i -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        begin
            w0 = k[127:96];
            w1 = k[95:64];
            w2 = k[63:32];
            w3 = k[31:0];
            t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
            w0 = w0 ^ t;
            w1 = w1 ^ w0;
            w2 = w2 ^ w1;
            w3 = w3 ^ w2;
            next_round_key = {w0, w1, w2, w3};
        end
    endfunction

    // SubBytes, ShiftRows and (optionally) MixColumns.
    function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] o;
        begin
            o = '0;
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    t[r + 4 * c] = SBOX[get_byte(s, r + 4 * ((c + r) % 4))];
                end
            end
            for (int c = 0; c < 4; c++) begin
                a0 = t[4 * c];
                a1 = t[4 * c + 1];
                a2 = t[4 * c + 2];
                a3 = t[4 * c + 3];
                all = a0 ^ a1 ^ a2 ^ a3;
                if (last) begin
                    o[127 - 32 * c -: 32] = {a0, a1, a2, a3};
                end else begin
                    o[127 - 32 * c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1),
                                             a1 ^ all ^ xtime(a1 ^ a2),
                                             a2 ^ all ^ xtime(a2 ^ a3),
                                             a3 ^ all ^ xtime(a3 ^ a0)};
                end
            end
            round_fn = o;
        end
    endfunction

endpackage

>>> src/actr_round.sv
module actr_round (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_last,
    input  logic [7:0]   i_rcon,
    input  logic         i_valid,
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    input  logic [127:0] i_data,
    output logic         o_valid,
    output logic [127:0] o_state,
    output logic [127:0] o_key,
    output logic [127:0] o_data
);
    logic [127:0] n_key;
    logic         r_valid;
    logic [127:0] r_state, r_key, r_data;

    assign n_key = actr_pkg::next_round_key(i_key, i_rcon);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= actr_pkg::round_fn(i_state, i_last) ^ n_key;
            r_key   <= n_key;
            r_data  <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;
    assign o_data  = r_data;
endmodule

>>> src/aes128_ctr_block_decrypt.sv
// AES-128 counter-mode block decryptor.
// Input channel: i_in_valid / o_in_stall with payload i_in (block index and
// 16 cipher bytes). A transfer happens when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall with payload o_out (16 plain bytes).
// Configuration: i_cfg_we, i_cfg_addr, i_cfg_data write key_high, key_low,
// iv_high, iv_low (indices 0..3); other indices are ignored. Write only while
// the pipeline is empty.
// Pipeline: stage 0 adds IV and index (128-bit counter) and applies the
// initial key; ten round stages follow, each doing one AES round and expanding
// its own round key alongside. A block passes stage 0 and every round register
// before output valid. Throughput is one block per cycle unless stalled.
// Stall: the whole pipeline, bubbles included, freezes while the output is
// valid and stalled, so stall reaches the input in that same cycle and only
// when the last stage holds a result that cannot leave.
// Reset (synchronous, active low) clears every valid bit and restores the
// default key and a zero IV.
module aes128_ctr_block_decrypt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  actr_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output actr_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_addr,
    input  logic [63:0]         i_cfg_data
);
    localparam int N = actr_pkg::NUM_ROUNDS;

    logic [63:0] r_key_high, r_key_low, r_iv_high, r_iv_low;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= actr_pkg::KEY_HIGH_RST;
            r_key_low  <= actr_pkg::KEY_LOW_RST;
            r_iv_high  <= '0;
            r_iv_low   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                actr_pkg::REG_KEY_HIGH: r_key_high <= i_cfg_data;
                actr_pkg::REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                actr_pkg::REG_IV_HIGH:  r_iv_high  <= i_cfg_data;
                actr_pkg::REG_IV_LOW:   r_iv_low   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advances unless a finished result is held by the receiver
    logic en;
    logic         v   [N+1];
    logic [127:0] st  [N+1];
    logic [127:0] ky  [N+1];
    logic [127:0] dat [N+1];

    assign en         = !(v[N] && i_out_stall);
    assign o_in_stall = !en;

    // stage 0: counter and whitening
    logic         r_v0;
    logic [127:0] r_st0, r_ky0, r_dat0;
    logic [64:0]  ctr_lo;
    logic [63:0]  ctr_hi;

    assign ctr_lo = {1'b0, r_iv_low} + {1'b0, i_in.block_index};
    assign ctr_hi = r_iv_high + {63'd0, ctr_lo[64]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st0  <= {ctr_hi, ctr_lo[63:0]} ^ {r_key_high, r_key_low};
            r_ky0  <= {r_key_high, r_key_low};
            r_dat0 <= {i_in.cipher_high, i_in.cipher_low};
        end
    end

    assign v[0]   = r_v0;
    assign st[0]  = r_st0;
    assign ky[0]  = r_ky0;
    assign dat[0] = r_dat0;

    for (genvar g = 0; g < N; g++) begin : g_round
        actr_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_last  (g == N - 1),
            .i_rcon  (actr_pkg::RCON[g]),
            .i_valid (v[g]),
            .i_state (st[g]),
            .i_key   (ky[g]),
            .i_data  (dat[g]),
            .o_valid (v[g+1]),
            .o_state (st[g+1]),
            .o_key   (ky[g+1]),
            .o_data  (dat[g+1])
        );
    end

    assign o_out_valid = v[N];
    assign o_out.plain_high = dat[N][127:64] ^ st[N][127:64];
    assign o_out.plain_low  = dat[N][63:0] ^ st[N][63:0];
endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

// Counter-mode AES-128 block decryptor: directed and random blocks against an
// in-bench predictor, with random idling on both channels and key/IV changes
// between phases while the pipeline is empty.
module testbench;
    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    actr_pkg::t_in_item  i_in;
    logic                o_out_valid;
    logic                i_out_stall;
    actr_pkg::t_out_item o_out;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_addr;
    logic [63:0]         i_cfg_data;

    // predictor copy of the registers
    logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;

    actr_pkg::t_out_item plain_queue [$];
    int          mismatches;
    int          send_idle_pct;
    int          stall_pct;
    int          hold_cycles;

    aes128_ctr_block_decrypt DUT (.*);

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    // GF(2^8) doubling
    function automatic logic [7:0] dbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // encrypt one 128-bit block (byte 0 in top bits) under the held key
    function automatic logic [127:0] aes_block(input logic [127:0] blk);
        logic [7:0] rk [176];
        logic [7:0] st [16];
        logic [7:0] sh [16];
        logic [7:0] w0, w1, w2, w3, tmp, mix;
        for (int i = 0; i < 8; i++) begin
            rk[i]     = key_hi_q[63 - 8 * i -: 8];
            rk[i + 8] = key_lo_q[63 - 8 * i -: 8];
        end
        for (int i = 16; i < 176; i += 4) begin
            w0 = rk[i - 4]; w1 = rk[i - 3]; w2 = rk[i - 2]; w3 = rk[i - 1];
            if (i % 16 == 0) begin
                tmp = w0;
                w0 = actr_pkg::SBOX[w1] ^ actr_pkg::RCON[i / 16 - 1];
                w1 = actr_pkg::SBOX[w2];
                w2 = actr_pkg::SBOX[w3];
                w3 = actr_pkg::SBOX[tmp];
            end
            rk[i] = rk[i - 16] ^ w0;
            rk[i + 1] = rk[i - 15] ^ w1;
            rk[i + 2] = rk[i - 14] ^ w2;
            rk[i + 3] = rk[i - 13] ^ w3;
        end
        for (int i = 0; i < 16; i++) st[i] = blk[127 - 8 * i -: 8] ^ rk[i];
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    sh[r + 4 * c] = actr_pkg::SBOX[st[r + 4 * ((c + r) % 4)]];
            for (int c = 0; c < 4; c++) begin
                mix = sh[4*c] ^ sh[4*c+1] ^ sh[4*c+2] ^ sh[4*c+3];
                for (int r = 0; r < 4; r++)
                    st[4*c+r] = (rnd < 10)
                        ? sh[4*c+r] ^ mix ^ dbl(sh[4*c+r] ^ sh[4*c+(r+1)%4])
                        : sh[4*c+r];
            end
            for (int i = 0; i < 16; i++) st[i] ^= rk[16 * rnd + i];
        end
        for (int i = 0; i < 16; i++) aes_block[127 - 8 * i -: 8] = st[i];
    endfunction

    function automatic actr_pkg::t_out_item decrypt_block(input actr_pkg::t_in_item it);
        logic [127:0] ctr;
        logic [127:0] ks;
        actr_pkg::t_out_item res;
        ctr = {iv_hi_q, iv_lo_q} + {64'd0, it.block_index};  // wraps mod 2^128
        ks = aes_block(ctr);
        res.plain_high = it.cipher_high ^ ks[127:64];
        res.plain_low  = it.cipher_low ^ ks[63:0];
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // only called with the pipeline empty
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            actr_pkg::REG_KEY_HIGH: key_hi_q = val;
            actr_pkg::REG_KEY_LOW:  key_lo_q = val;
            actr_pkg::REG_IV_HIGH:  iv_hi_q = val;
            actr_pkg::REG_IV_LOW:   iv_lo_q = val;
            default: ;
        endcase
    endtask

    task automatic load_key_iv(input logic [63:0] kh, kl, ivh, ivl);
        write_reg(actr_pkg::REG_KEY_HIGH, kh);
        write_reg(actr_pkg::REG_KEY_LOW, kl);
        write_reg(actr_pkg::REG_IV_HIGH, ivh);
        write_reg(actr_pkg::REG_IV_LOW, ivl);
    endtask

    // one transfer on the input channel; expectation queued on acceptance;
    // valid stays up afterwards, the next idle cycle or drain drops it
    task automatic send_block(input actr_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        plain_queue = {plain_queue, decrypt_block(it)};
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (plain_queue.size() != 0) @(posedge i_clk);
        repeat (15) @(posedge i_clk);
    endtask

    task automatic send_random(input int n, input int idx_mode);
        actr_pkg::t_in_item it;
        for (int k = 0; k < n; k++) begin
            it.cipher_high = rand64();
            it.cipher_low  = rand64();
            case (idx_mode)
                0: it.block_index = 64'(k);           // sequential stream
                1: it.block_index = rand64();
                default: it.block_index = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
            endcase
            send_block(it);
        end
    endtask

    // output side: random stall, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        actr_pkg::t_out_item exp_item;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (plain_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", o_out);
            end else begin
                exp_item = plain_queue.pop_front();
                if (o_out.plain_high !== exp_item.plain_high ||
                        o_out.plain_low !== exp_item.plain_low) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("plain mismatch: exp %h_%h got %h_%h",
                                 exp_item.plain_high, exp_item.plain_low,
                                 o_out.plain_high, o_out.plain_low);
                end
            end
        end
    end

    task automatic test_directed();
        actr_pkg::t_in_item it;
        // default key, zero IV: a few plain counter values
        it = '{64'd0, 64'd0, 64'd0};                       send_block(it);
        it = '{64'd1, '1, '1};                             send_block(it);
        it = '{'1, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210}; send_block(it);
        drain();
        // low-half carry into high half, and full 128-bit wrap
        load_key_iv('1, '1, 64'd5, '1);
        it = '{64'd0, '1, 64'd0};  send_block(it);
        it = '{64'd1, 64'd0, '1};  send_block(it);
        it = '{'1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555}; send_block(it);
        drain();
        load_key_iv('0, '0, '1, '1);
        it = '{64'd0, '0, '0};  send_block(it);
        it = '{64'd1, '0, '0};  send_block(it);
        it = '{'1, '1, '1};     send_block(it);
        drain();
        // FIPS-197 style key, alternating bits
        load_key_iv(64'h0001020304050607, 64'h08090A0B0C0D0E0F,
                    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        for (int k = 0; k < 6; k++) begin
            it = '{64'd1 << (k * 11), rand64(), rand64()};
            send_block(it);
        end
        drain();
    endtask

    task automatic test_random_phases();
        int idle_tab [4] = '{0, 87, 0, 29};
        int stall_tab [4] = '{0, 0, 87, 29};
        for (int ph = 0; ph < 8; ph++) begin
            load_key_iv(rand64(), rand64(), rand64(),
                        (ph % 3 == 0) ? 64'hFFFF_FFFF_FFFF_FF00 | $urandom_range(255)
                                      : rand64());
            send_idle_pct = idle_tab[ph % 4];
            stall_pct     = stall_tab[ph % 4];
            send_random(120, 0);
            send_random(110, ph % 2 ? 2 : 1);
            drain();
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    task automatic test_backpressure();
        load_key_iv(rand64(), rand64(), '0, '0);
        hold_cycles = 60;
        send_random(40, 1);
        // wait for all results before resuming
        i_in_valid <= 1'b0;
        while (plain_queue.size() != 0) @(posedge i_clk);
        send_random(20, 0);
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = actr_pkg::REG_KEY_HIGH;
        i_cfg_data    = '0;
        mismatches    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 0;
        key_hi_q      = actr_pkg::KEY_HIGH_RST;
        key_lo_q      = actr_pkg::KEY_LOW_RST;
        iv_hi_q       = '0;
        iv_lo_q       = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random_phases();

        if (mismatches == 0 && plain_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
